// ----- rtl/core/deck_rrt_pkg.sv -----
// Shared types, constants and elaboration-time functions for the deck/world point mapper.
// Holds the register index codes, the pivot tables and the sine table generator.
// No dependencies.
package deck_rrt_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_HULL_POS_X   = 3'd0;
  localparam logic [2:0] REG_HULL_POS_Z   = 3'd1;
  localparam logic [2:0] REG_HULL_YAW     = 3'd2;
  localparam logic [2:0] REG_DECK_TILES_X = 3'd3;
  localparam logic [2:0] REG_DECK_TILES_Z = 3'd4;
  localparam logic [2:0] REG_HULL_TYPE    = 3'd5;

  // Fixed field widths
  localparam int POS_W    = 21;
  localparam int YAW_W    = 11;
  localparam int TILES_W  = 7;
  localparam int TYPE_W   = 8;
  localparam int CFG_W    = 21;
  localparam int PT_W     = 22;
  localparam int OUT_W    = 24;
  localparam int TRIG_W   = 18;   // sine values span -65536..65536
  localparam int REC_W    = 15;   // recenter offset spans -64..8704
  localparam int DIFF_W   = 23;   // point minus offset
  localparam int PROD_W   = DIFF_W + TRIG_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int FRAC_W   = 16;

  // Fine units per 8-tile zone, half a tile per tile of width
  localparam int FINE_PER_TILE  = 128;
  localparam int TILES_PER_ZONE = 8;
  localparam int ZONE_FINE      = TILES_PER_ZONE * (FINE_PER_TILE / 2);

  // Pivot per hull type, types 1..14 tabled
  localparam int PIVOT_W = 11;
  localparam logic signed [PIVOT_W-1:0] PIVOT_X [15] = '{
    11'sd0, -11'sd64, 11'sd0, -11'sd64, 11'sd0, -11'sd64, -11'sd64, -11'sd64,
    -11'sd64, -11'sd64, 11'sd0, 11'sd0, -11'sd64, -11'sd64, -11'sd64
  };
  localparam logic signed [PIVOT_W-1:0] PIVOT_Z [15] = '{
    11'sd0, -11'sd64, -11'sd64, 11'sd0, 11'sd0, 11'sd512, 11'sd512, 11'sd512,
    11'sd512, 11'sd192, -11'sd64, -11'sd64, 11'sd0, 11'sd0, 11'sd0
  };

  // Hull geometry seen by the datapath
  typedef struct packed {
    logic [POS_W-1:0]         hull_pos_x;
    logic [POS_W-1:0]         hull_pos_z;
    logic signed [REC_W-1:0]  rec_x;
    logic signed [REC_W-1:0]  rec_z;
  } deck_geom_t;

  // Sine and cosine of the current yaw
  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  // 2*pi in Q60
  localparam longint unsigned TWO_PI_Q60 = 64'h6487ED5110B4611A;

  // (a*b) >> 60, truncated, for operands below 2^61
  function automatic longint unsigned mul_q60(longint unsigned a, longint unsigned b);
    longint unsigned ah, al, bh, bl, mid;
    ah  = a >> 32;
    al  = a & 64'h00000000FFFFFFFF;
    bh  = b >> 32;
    bl  = b & 64'h00000000FFFFFFFF;
    mid = ah * bl + al * bh + ((al * bl) >> 32);
    return ((ah * bh) << 4) + (mid >> 28);
  endfunction

  // Taylor term update: divide by (n+1)*(n+2)
  function automatic longint unsigned div_term(longint unsigned t, int n);
    longint unsigned r;
    case (n)
      1:  r = t / 6;
      3:  r = t / 20;
      5:  r = t / 42;
      7:  r = t / 72;
      9:  r = t / 110;
      11: r = t / 156;
      13: r = t / 210;
      15: r = t / 272;
      17: r = t / 342;
      19: r = t / 420;
      21: r = t / 506;
      23: r = t / 600;
      25: r = t / 702;
      27: r = t / 812;
      29: r = t / 930;
      31: r = t / 1056;
      33: r = t / 1190;
      35: r = t / 1332;
      37: r = t / 1482;
      39: r = t / 1640;
      41: r = t / 1806;
      43: r = t / 1980;
      45: r = t / 2162;
      47: r = t / 2352;
      49: r = t / 2550;
      51: r = t / 2756;
      53: r = t / 2970;
      55: r = t / 3192;
      57: r = t / 3422;
      59: r = t / 3660;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

  // Truncated sin*65536 over the first quarter, circle of 2^lg units
  function automatic int quarter_sine(longint unsigned k, int lg);
    longint unsigned quarter, amask, x, x2, term, sum;
    int n;
    bit sub;
    quarter = 64'd1 << (lg - 2);
    amask   = (64'd1 << lg) - 64'd1;
    sub     = 1'b1;
    n       = 1;
    if (k == 0) return 0;
    if (k >= quarter) return 65536;
    x    = (TWO_PI_Q60 >> lg) * k + (((TWO_PI_Q60 & amask) * k) >> lg);
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    while (term != 0 && n < 61) begin
      term = div_term(mul_q60(term, x2), n);
      n    = n + 2;
      if (sub) sum = sum - term;
      else sum = sum + term;
      sub = !sub;
    end
    return int'(sum >> 44);
  endfunction

  // Full-circle sine table entry i, circle of 2^lg units
  function automatic int sine_entry(int i, int lg);
    int half, quarter, k, v;
    half    = 1 << (lg - 1);
    quarter = 1 << (lg - 2);
    k = i & (half - 1);
    if (k > quarter) k = half - k;
    v = quarter_sine(longint'(k), lg);
    return (i >= half) ? -v : v;
  endfunction

endpackage

// ----- rtl/core/deck_rrt_cfg.sv -----
// Configuration registers and recenter offset logic for the deck/world point mapper.
// Depends on deck_rrt_pkg.
module deck_rrt_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [2:0]                           cfg_index,
  input  logic [deck_rrt_pkg::CFG_W-1:0]       cfg_data,
  output logic [deck_rrt_pkg::YAW_W-1:0]       yaw_nxt,
  output deck_rrt_pkg::deck_geom_t             geom
);
  import deck_rrt_pkg::*;

  logic [POS_W-1:0]   hull_pos_x_r, hull_pos_z_r;
  logic [YAW_W-1:0]   hull_yaw_r;
  logic [TILES_W-1:0] deck_tiles_x_r, deck_tiles_z_r;
  logic [TYPE_W-1:0]  hull_type_r;

  logic [4:0]                 zones_x, zones_z;
  logic signed [PIVOT_W-1:0]  pivot_x, pivot_z;

  // Yaw next value feeds the sine table so its output tracks the register
  always_comb begin
    yaw_nxt = hull_yaw_r;
    if (!rst_n) yaw_nxt = '0;
    else if (cfg_we && cfg_index == REG_HULL_YAW) yaw_nxt = cfg_data[YAW_W-1:0];
  end

  // Register writes, out-of-range indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hull_pos_x_r   <= '0;
      hull_pos_z_r   <= '0;
      hull_yaw_r     <= '0;
      deck_tiles_x_r <= TILES_W'(1);
      deck_tiles_z_r <= TILES_W'(1);
      hull_type_r    <= '0;
    end else begin
      hull_yaw_r <= yaw_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_HULL_POS_X:   hull_pos_x_r   <= cfg_data[POS_W-1:0];
          REG_HULL_POS_Z:   hull_pos_z_r   <= cfg_data[POS_W-1:0];
          REG_DECK_TILES_X: deck_tiles_x_r <= cfg_data[TILES_W-1:0];
          REG_DECK_TILES_Z: deck_tiles_z_r <= cfg_data[TILES_W-1:0];
          REG_HULL_TYPE:    hull_type_r    <= cfg_data[TYPE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Pivot lookup, unknown types give zero
  always_comb begin
    pivot_x = '0;
    pivot_z = '0;
    if (hull_type_r inside {[8'd1:8'd14]}) begin
      pivot_x = PIVOT_X[hull_type_r[3:0]];
      pivot_z = PIVOT_Z[hull_type_r[3:0]];
    end
  end

  // Recenter offset: zone-rounded half size plus pivot
  assign zones_x = 5'((9'(deck_tiles_x_r) + 9'd7) >> 3);
  assign zones_z = 5'((9'(deck_tiles_z_r) + 9'd7) >> 3);

  assign geom.hull_pos_x = hull_pos_x_r;
  assign geom.hull_pos_z = hull_pos_z_r;
  assign geom.rec_x = REC_W'(signed'({1'b0, zones_x}) * REC_W'(ZONE_FINE))
                      + REC_W'(pivot_x);
  assign geom.rec_z = REC_W'(signed'({1'b0, zones_z}) * REC_W'(ZONE_FINE))
                      + REC_W'(pivot_z);

endmodule

// ----- rtl/core/deck_rrt_sine_rom.sv -----
// Sine table with two registered read ports, one for sine and one for cosine.
// Contents built at elaboration from deck_rrt_pkg::sine_entry.
module deck_rrt_sine_rom #(
  parameter int ANGLE_UNITS = 2048
) (
  input  logic                              clk,
  input  logic [deck_rrt_pkg::YAW_W-1:0]    yaw,
  output deck_rrt_pkg::trig_t               trig
);
  import deck_rrt_pkg::*;

  localparam int ANGLE_BITS = $clog2(ANGLE_UNITS);
  localparam int ADDR_W     = ANGLE_BITS;
  localparam logic [ADDR_W-1:0] QUARTER = ADDR_W'(ANGLE_UNITS / 4);

  logic signed [TRIG_W-1:0] rom_mem [ANGLE_UNITS];
  logic [ADDR_W-1:0]        sin_addr, cos_addr;
  logic signed [TRIG_W-1:0] sin_r, cos_r;

  // Constant contents
  for (genvar g = 0; g < ANGLE_UNITS; g++) begin : g_rom
    assign rom_mem[g] = TRIG_W'(sine_entry(g, ANGLE_BITS));
  end

  // Yaw taken modulo the circle; cosine is a quarter turn ahead
  if (ADDR_W > YAW_W) begin : g_wide
    assign sin_addr = ADDR_W'(yaw);
  end else begin : g_narrow
    assign sin_addr = yaw[ADDR_W-1:0];
  end
  assign cos_addr = sin_addr + QUARTER;

  always_ff @(posedge clk) begin
    sin_r <= rom_mem[sin_addr];
    cos_r <= rom_mem[cos_addr];
  end

  assign trig.sin_v = sin_r;
  assign trig.cos_v = cos_r;

endmodule

// ----- rtl/core/deck_rrt_datapath.sv -----
// Three-stage rotation datapath: offset subtract, four products, sum/shift/offset add.
// Depends on deck_rrt_pkg.
module deck_rrt_datapath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_take,
  input  logic                                    in_operation,
  input  logic signed [deck_rrt_pkg::PT_W-1:0]    in_point_x,
  input  logic signed [deck_rrt_pkg::PT_W-1:0]    in_point_z,
  input  deck_rrt_pkg::deck_geom_t                geom,
  input  deck_rrt_pkg::trig_t                     trig,
  output logic                                    out_valid,
  output logic signed [deck_rrt_pkg::OUT_W-1:0]   out_mapped_x,
  output logic signed [deck_rrt_pkg::OUT_W-1:0]   out_mapped_z
);
  import deck_rrt_pkg::*;

  logic signed [DIFF_W-1:0] sub_x, sub_z, add_x, add_z;
  logic signed [DIFF_W-1:0] pos_x_s, pos_z_s, rec_x_s, rec_z_s;

  logic                     a_valid_r, b_valid_r, out_valid_r;
  logic                     a_op_r, b_op_r;
  logic signed [DIFF_W-1:0] a_dx_r, a_dz_r;
  logic signed [PROD_W-1:0] b_xc_r, b_zs_r, b_zc_r, b_xs_r;
  logic signed [SUM_W-1:0]  sum_x, sum_z;
  logic signed [SUM_W-FRAC_W-1:0] rot_x, rot_z;
  logic signed [OUT_W-1:0]  res_x_nxt, res_z_nxt, res_x_r, res_z_r;

  assign pos_x_s = DIFF_W'(signed'({1'b0, geom.hull_pos_x}));
  assign pos_z_s = DIFF_W'(signed'({1'b0, geom.hull_pos_z}));
  assign rec_x_s = DIFF_W'(geom.rec_x);
  assign rec_z_s = DIFF_W'(geom.rec_z);

  // Offset removed before rotation and added after, by direction
  assign sub_x = in_operation ? pos_x_s : rec_x_s;
  assign sub_z = in_operation ? pos_z_s : rec_z_s;
  assign add_x = b_op_r ? rec_x_s : pos_x_s;
  assign add_z = b_op_r ? rec_z_s : pos_z_s;

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= in_take;
      b_valid_r   <= a_valid_r;
      out_valid_r <= b_valid_r;
    end
  end

  // Stage A: point minus offset
  always_ff @(posedge clk) begin
    a_op_r <= in_operation;
    a_dx_r <= DIFF_W'(in_point_x) - sub_x;
    a_dz_r <= DIFF_W'(in_point_z) - sub_z;
  end

  // Stage B: rotation products
  always_ff @(posedge clk) begin
    b_op_r <= a_op_r;
    b_xc_r <= PROD_W'(a_dx_r * trig.cos_v);
    b_zs_r <= PROD_W'(a_dz_r * trig.sin_v);
    b_zc_r <= PROD_W'(a_dz_r * trig.cos_v);
    b_xs_r <= PROD_W'(a_dx_r * trig.sin_v);
  end

  // Stage C: forward uses R, inverse the transpose; arithmetic shift floors
  always_comb begin
    if (b_op_r) begin
      sum_x = SUM_W'(b_xc_r) - SUM_W'(b_zs_r);
      sum_z = SUM_W'(b_zc_r) + SUM_W'(b_xs_r);
    end else begin
      sum_x = SUM_W'(b_xc_r) + SUM_W'(b_zs_r);
      sum_z = SUM_W'(b_zc_r) - SUM_W'(b_xs_r);
    end
    rot_x     = sum_x[SUM_W-1:FRAC_W];
    rot_z     = sum_z[SUM_W-1:FRAC_W];
    res_x_nxt = OUT_W'(rot_x) + OUT_W'(add_x);
    res_z_nxt = OUT_W'(rot_z) + OUT_W'(add_z);
  end

  always_ff @(posedge clk) begin
    res_x_r <= res_x_nxt;
    res_z_r <= res_z_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_mapped_x = res_x_r;
  assign out_mapped_z = res_z_r;

endmodule

// ----- rtl/core/deck_root_rotation_transform.sv -----
// Top level of the deck/world point mapper for a moving hull.
// Depends on deck_rrt_pkg, deck_rrt_cfg, deck_rrt_sine_rom and deck_rrt_datapath.
//
// Usage:
//   Config: write hull position, yaw, deck size and hull type through cfg_we,
//   cfg_index and cfg_data; a write lands at the clock edge with cfg_we high.
//   The sine table is addressed from the incoming yaw, so an item started in
//   the cycle after a yaw write already sees the new angle.
//   Input: an item (in_operation, in_point_x, in_point_z) is taken at each edge
//   with start high and busy low. busy is low whenever reset is released.
//   Output: out_valid strobes for one cycle with out_mapped_x/out_mapped_z.
//   A taken item passes the stage A, stage B and result registers before out_valid.
//   Throughput: one item per clock, set by the three-register datapath
//   (offset subtract, four 23x18 products, sum/shift/offset add).
//   Reset (synchronous, active low) restores register defaults and flushes
//   the pipeline; items in flight are dropped. The receiver cannot stall:
//   every result is shown for exactly one cycle.
module deck_root_rotation_transform #(
  parameter int ANGLE_UNITS = 2048
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [2:0]                              cfg_index,
  input  logic [deck_rrt_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    in_operation,
  input  logic signed [deck_rrt_pkg::PT_W-1:0]    in_point_x,
  input  logic signed [deck_rrt_pkg::PT_W-1:0]    in_point_z,
  output logic                                    out_valid,
  output logic signed [deck_rrt_pkg::OUT_W-1:0]   out_mapped_x,
  output logic signed [deck_rrt_pkg::OUT_W-1:0]   out_mapped_z
);
  import deck_rrt_pkg::*;

  logic [YAW_W-1:0] yaw_nxt;
  deck_geom_t       geom;
  trig_t            trig;
  logic             in_take;

  // Fully pipelined, so only reset holds items off
  assign busy    = ~rst_n;
  assign in_take = start & ~busy;

  deck_rrt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .yaw_nxt   (yaw_nxt),
    .geom      (geom)
  );

  deck_rrt_sine_rom #(
    .ANGLE_UNITS (ANGLE_UNITS)
  ) u_rom (
    .clk  (clk),
    .yaw  (yaw_nxt),
    .trig (trig)
  );

  deck_rrt_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_take      (in_take),
    .in_operation (in_operation),
    .in_point_x   (in_point_x),
    .in_point_z   (in_point_z),
    .geom         (geom),
    .trig         (trig),
    .out_valid    (out_valid),
    .out_mapped_x (out_mapped_x),
    .out_mapped_z (out_mapped_z)
  );

endmodule
